[hdl/line_table_offset_to_line_column_defines.svh]
// ---------------------------------------------------------------------------
// Line table assertion macros
// Shared property forms for the line table checks. Each macro expects clk and
// rst in scope and reports a failure through $error.
// ---------------------------------------------------------------------------
`ifndef LINE_TABLE_OFFSET_TO_LINE_COLUMN_DEFINES_SVH
`define LINE_TABLE_OFFSET_TO_LINE_COLUMN_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LTOC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LTOC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/ltoc_pkg.sv]
// ---------------------------------------------------------------------------
// Line table package
// Word types, operation codes, controller states and shared constants for the
// offset to line/column lookup block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ltoc_pkg;

  localparam int MAX_LINES_DEF   = 1024;
  localparam int OFFSET_BITS_DEF = 16;

  localparam int OP_W     = 2;
  localparam int BYTE_W   = 8;
  localparam int QOFF_W   = 16;
  localparam int LINE_W   = 10;
  localparam int COLUMN_W = 16;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
  // Spare code: the block takes the word and does nothing with it.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] source_byte;
    logic [QOFF_W-1:0] query_offset;
  } req_word_t;

  typedef struct packed {
    logic [LINE_W-1:0]   line_index;
    logic [COLUMN_W-1:0] column_index;
    logic                capacity_dropped;
  } rsp_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic query_start;
    logic search_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic search_more;
    logic out_free;
  } status_t;

endpackage

[hdl/ltoc_ctrl.sv]
// ---------------------------------------------------------------------------
// Line table controller
// Sequences loads, clears and the binary search of a query, and holds off new
// words while a query is in progress.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ltoc_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  input  logic [ltoc_pkg::OP_W-1:0]   operation,
  input  ltoc_pkg::status_t           status,
  output logic                        req_stall,
  output ltoc_pkg::cmd_t              cmd
);

  ltoc_pkg::state_t state;
  ltoc_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ltoc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    case (state)
      ltoc_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          case (operation)
            ltoc_pkg::OP_LOAD: begin
              cmd.load = 1'b1;
            end
            ltoc_pkg::OP_CLEAR: begin
              cmd.clear = 1'b1;
            end
            ltoc_pkg::OP_QUERY: begin
              cmd.query_start = 1'b1;
              state_next = status.search_more ? ltoc_pkg::ST_SEARCH : ltoc_pkg::ST_FINISH;
            end
            default: begin
            end
          endcase
        end
      end
      ltoc_pkg::ST_SEARCH: begin
        cmd.search_step = 1'b1;
        if (!status.search_more) begin
          state_next = ltoc_pkg::ST_FINISH;
        end
      end
      ltoc_pkg::ST_FINISH: begin
        // The result waits here until the output register can take it.
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ltoc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ltoc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[hdl/ltoc_dpath.sv]
// ---------------------------------------------------------------------------
// Line table datapath
// Line start and text end memories, load bookkeeping, binary search bounds
// and the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ltoc_dpath #(
  parameter int MAX_LINES   = ltoc_pkg::MAX_LINES_DEF,
  parameter int OFFSET_BITS = ltoc_pkg::OFFSET_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  ltoc_pkg::req_word_t req,
  input  ltoc_pkg::cmd_t      cmd,
  input  logic                rsp_stall,
  output ltoc_pkg::status_t   status,
  output logic                rsp_valid,
  output ltoc_pkg::rsp_word_t rsp
);

  localparam int IW   = $clog2(MAX_LINES);
  localparam int CW   = $clog2(MAX_LINES + 1);
  localparam int OW   = OFFSET_BITS;
  localparam int EW   = OFFSET_BITS + 1;
  localparam int CMPW = (EW > ltoc_pkg::QOFF_W) ? EW : ltoc_pkg::QOFF_W;

  logic [OW-1:0] start_mem [MAX_LINES];
  logic [EW-1:0] end_mem   [MAX_LINES];

  logic [CW-1:0] line_count, line_count_next;
  logic [OW:0]   byte_count, byte_count_next;
  logic          line_open, line_open_next;
  logic          after_cr, after_cr_next;
  logic          overflow_seen, overflow_seen_next;
  logic [EW-1:0] cur_end, cur_end_next;

  logic [CW-1:0] lo, lo_next;
  logic [CW-1:0] hi, hi_next;
  logic [CW-1:0] mid, mid_next;
  logic [ltoc_pkg::QOFF_W-1:0] query_off;
  logic [OW-1:0] start_rd;
  logic [EW-1:0] end_rd;

  logic [OW-1:0] pos;
  logic          is_lf, is_cr, skip_lf, lines_full;
  logic          start_we, end_we;
  logic [IW-1:0] wr_idx;
  logic [EW-1:0] end_val;

  logic [CW-1:0] span;
  logic          more;
  logic          rd_en;
  logic [IW-1:0] rd_idx;

  logic [OW-1:0]   line_start;
  logic [EW-1:0]   line_end;
  logic [CMPW-1:0] qoff_ext, vis, col;

  // ---------------- load bookkeeping ----------------
  assign pos        = byte_count[OW-1:0];
  assign is_lf      = (req.source_byte == ltoc_pkg::CHAR_LF);
  assign is_cr      = (req.source_byte == ltoc_pkg::CHAR_CR);
  assign skip_lf    = after_cr & is_lf;
  assign lines_full = (line_count >= CW'(MAX_LINES));

  always_comb begin
    line_count_next    = line_count;
    byte_count_next    = byte_count;
    line_open_next     = line_open;
    after_cr_next      = after_cr;
    overflow_seen_next = overflow_seen;
    cur_end_next       = cur_end;
    start_we           = 1'b0;
    end_we             = 1'b0;
    wr_idx             = IW'(line_count - CW'(1));
    end_val            = cur_end;
    if (cmd.clear) begin
      line_count_next    = CW'(1);
      byte_count_next    = '0;
      line_open_next     = 1'b1;
      after_cr_next      = 1'b0;
      overflow_seen_next = 1'b0;
      cur_end_next       = '0;
    end else if (cmd.load) begin
      if (byte_count[OW]) begin
        // Offset space is used up: the byte is dropped.
        overflow_seen_next = 1'b1;
      end else begin
        byte_count_next = byte_count + 1'b1;
        after_cr_next   = !skip_lf && is_cr;
        if (!skip_lf) begin
          if (!line_open && lines_full) begin
            overflow_seen_next = 1'b1;
          end else begin
            if (!line_open) begin
              start_we        = 1'b1;
              wr_idx          = line_count[IW-1:0];
              line_count_next = line_count + 1'b1;
              end_val         = {1'b0, pos};
            end
            if (is_lf || is_cr) begin
              line_open_next = 1'b0;
            end else begin
              line_open_next = 1'b1;
              end_val        = {1'b0, pos} + 1'b1;
            end
            // A terminator writes the current end back, so a line that is
            // closed before any text still has its end stored.
            end_we       = 1'b1;
            cur_end_next = end_val;
          end
        end
      end
    end
  end

  // ---------------- search bounds ----------------
  always_comb begin
    lo_next = lo;
    hi_next = hi;
    if (cmd.query_start) begin
      lo_next = '0;
      hi_next = line_count;
    end else if (cmd.search_step) begin
      if (CMPW'(start_rd) <= CMPW'(query_off)) begin
        lo_next = mid;
      end else begin
        hi_next = mid;
      end
    end
    span     = hi_next - lo_next;
    more     = (span > CW'(1));
    mid_next = lo_next + (span >> 1);
    rd_en    = cmd.query_start | cmd.search_step;
    rd_idx   = more ? mid_next[IW-1:0] : lo_next[IW-1:0];
  end

  assign status.search_more = more;
  assign status.out_free    = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    lo  <= lo_next;
    hi  <= hi_next;
    mid <= mid_next;
    if (cmd.query_start) begin
      query_off <= req.query_offset;
    end
  end

  // ---------------- memories ----------------
  always_ff @(posedge clk) begin
    if (start_we) begin
      start_mem[wr_idx] <= pos;
    end
    if (end_we) begin
      end_mem[wr_idx] <= end_val;
    end
    if (rd_en) begin
      start_rd <= start_mem[rd_idx];
      end_rd   <= end_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count    <= CW'(1);
      byte_count    <= '0;
      line_open     <= 1'b1;
      after_cr      <= 1'b0;
      overflow_seen <= 1'b0;
      cur_end       <= '0;
    end else begin
      line_count    <= line_count_next;
      byte_count    <= byte_count_next;
      line_open     <= line_open_next;
      after_cr      <= after_cr_next;
      overflow_seen <= overflow_seen_next;
      cur_end       <= cur_end_next;
    end
  end

  // ---------------- result ----------------
  // Line zero always starts at offset zero, and the last line's text end
  // lives in cur_end, so neither depends on a memory entry written earlier.
  assign line_start = (lo == '0) ? '0 : start_rd;
  assign line_end   = (lo == line_count - CW'(1)) ? cur_end : end_rd;
  assign qoff_ext   = CMPW'(query_off);
  assign vis        = (qoff_ext < CMPW'(line_end)) ? qoff_ext : CMPW'(line_end);
  assign col        = vis - CMPW'(line_start);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp.line_index       <= ltoc_pkg::LINE_W'(lo);
      rsp.column_index     <= col[ltoc_pkg::COLUMN_W-1:0];
      rsp.capacity_dropped <= overflow_seen;
    end
  end

endmodule

[hdl/line_table_offset_to_line_column.sv]
// Load and clear words leave the controller idle; a new word is taken the next cycle.
// A query passes through an accept step, the binary search with one line start probe
// per cycle, and a result step before the next word is taken.
// The result step waits for as long as an earlier result word is still stalled.
// The result word appears in an output register the cycle after the result step.
// Reset and the clear operation restore the empty table without a memory sweep.
// ---------------------------------------------------------------------------
// Line table offset to line/column lookup
// Builds a table of line starts from loaded source bytes and answers offset
// queries with a line and a clamped column.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "line_table_offset_to_line_column_defines.svh"

module line_table_offset_to_line_column #(
  parameter int MAX_LINES   = ltoc_pkg::MAX_LINES_DEF,
  parameter int OFFSET_BITS = ltoc_pkg::OFFSET_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  ltoc_pkg::req_word_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output ltoc_pkg::rsp_word_t rsp
);

  ltoc_pkg::cmd_t    cmd;
  ltoc_pkg::status_t status;
  logic              query_take;
  logic              out_busy;

  ltoc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .operation (req.operation),
    .status    (status),
    .req_stall (req_stall),
    .cmd       (cmd)
  );

  ltoc_dpath #(
    .MAX_LINES   (MAX_LINES),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .rsp_stall (rsp_stall),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  assign query_take = req_valid && !req_stall && (req.operation == ltoc_pkg::OP_QUERY);
  assign out_busy   = rsp_valid && rsp_stall;

  // An accepted query keeps the input held off while it searches.
  `LTOC_ASSERT_NEXT(a_query_holds_input, query_take, req_stall, "query accepted but input not held")

  // A result is only written into a free output register.
  `LTOC_ASSERT_NOW(a_finish_when_free, cmd.finish, !out_busy, "result overwrote a pending word")

  // A new result word comes only from a finished search.
  `LTOC_ASSERT_NOW(a_rsp_from_finish, $rose(rsp_valid), $past(cmd.finish), "result without a query")

endmodule

[sim/line_table_offset_to_line_column_test.sv]
// ---------------------------------------------------------------------------
// Line table offset to line/column lookup: self-checking testbench
// Loads source bytes, queries offsets and clears the table through the
// valid/stall request channel. Every lookup result is compared field by field
// against a local line table model or a directed row's own word. A directed table
// comes first, then random text sessions with queries in between.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_table_offset_to_line_column_test;

  localparam int BYTE_W   = ltoc_pkg::BYTE_W;
  localparam int QOFF_W   = ltoc_pkg::QOFF_W;
  localparam int LINE_W   = ltoc_pkg::LINE_W;
  localparam int COLUMN_W = ltoc_pkg::COLUMN_W;

  localparam int MAX_LINES    = ltoc_pkg::MAX_LINES_DEF;
  localparam int BYTE_LIMIT   = 1 << ltoc_pkg::OFFSET_BITS_DEF;
  localparam int RANDOM_ITEMS = 450;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    logic [ltoc_pkg::OP_W-1:0] op;
    logic [BYTE_W-1:0]         data;
    logic [QOFF_W-1:0]         offset;
    logic                      typed;
    ltoc_pkg::rsp_word_t       want;
  } directed_row_t;

  localparam ltoc_pkg::rsp_word_t EMPTY_LOOKUP = '0;
  localparam int DIRECTED_ROWS = 23;

  // Rows with typed set carry their own expected word; the rest use the model.
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{ltoc_pkg::OP_QUERY,  8'h00, 16'h0000, 1'b1, EMPTY_LOOKUP},
    '{ltoc_pkg::OP_QUERY,  8'h00, 16'hFFFF, 1'b1, EMPTY_LOOKUP},
    '{ltoc_pkg::OP_UNUSED, 8'hFF, 16'hFFFF, 1'b0, EMPTY_LOOKUP},
    '{ltoc_pkg::OP_LOAD,   8'h61, 16'h0000, 1'b0, EMPTY_LOOKUP},
    '{ltoc_pkg::OP_LOAD,   ltoc_pkg::CHAR_CR, 16'h0000, 1'b0, EMPTY_LOOKUP},
    '{ltoc_pkg::OP_LOAD,   ltoc_pkg::CHAR_LF, 16'h0000, 1'b0, EMPTY_LOOKUP},
    '{ltoc_pkg::OP_LOAD,   8'h62, 16'h0000, 1'b0, EMPTY_LOOKUP},
    '{ltoc_pkg::OP_LOAD,   ltoc_pkg::CHAR_LF, 16'h0000, 1'b0, EMPTY_LOOKUP},
    '{ltoc_pkg::OP_LOAD,   ltoc_pkg::CHAR_LF, 16'h0000, 1'b0, EMPTY_LOOKUP},
    '{ltoc_pkg::OP_LOAD,   ltoc_pkg::CHAR_CR, 16'h0000, 1'b0, EMPTY_LOOKUP},
    '{ltoc_pkg::OP_LOAD,   ltoc_pkg::CHAR_CR, 16'h0000, 1'b0, EMPTY_LOOKUP},
    '{ltoc_pkg::OP_LOAD,   8'h00, 16'h0000, 1'b0, EMPTY_LOOKUP},
    '{ltoc_pkg::OP_LOAD,   8'hFF, 16'h0000, 1'b0, EMPTY_LOOKUP},
    '{ltoc_pkg::OP_LOAD,   ltoc_pkg::CHAR_LF, 16'h0000, 1'b0, EMPTY_LOOKUP},
    '{ltoc_pkg::OP_QUERY,  8'h00, 16'h0000, 1'b0, EMPTY_LOOKUP},
    '{ltoc_pkg::OP_QUERY,  8'h00, 16'h0001, 1'b0, EMPTY_LOOKUP},
    '{ltoc_pkg::OP_QUERY,  8'h00, 16'h0003, 1'b0, EMPTY_LOOKUP},
    '{ltoc_pkg::OP_QUERY,  8'h00, 16'h0006, 1'b0, EMPTY_LOOKUP},
    '{ltoc_pkg::OP_QUERY,  8'h00, 16'h0008, 1'b0, EMPTY_LOOKUP},
    '{ltoc_pkg::OP_QUERY,  8'h00, 16'h000B, 1'b0, EMPTY_LOOKUP},
    '{ltoc_pkg::OP_QUERY,  8'h00, 16'hFFFF, 1'b0, EMPTY_LOOKUP},
    '{ltoc_pkg::OP_CLEAR,  8'hFF, 16'hFFFF, 1'b0, EMPTY_LOOKUP},
    '{ltoc_pkg::OP_QUERY,  8'h00, 16'hFFFF, 1'b1, EMPTY_LOOKUP}
  };

  logic                clk;
  logic                rst;
  logic                req_valid;
  logic                req_stall;
  ltoc_pkg::req_word_t req_word;
  logic                rsp_valid;
  logic                rsp_stall;
  ltoc_pkg::rsp_word_t rsp_word;

  line_table_offset_to_line_column dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req_word),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp_word)
  );

  // Local copy of the line table.
  int unsigned src_line_start [MAX_LINES];
  int unsigned src_text_end [MAX_LINES];
  int unsigned src_lines;
  int unsigned src_bytes;
  bit          src_open;
  bit          src_after_cr;
  bit          src_dropped;

  ltoc_pkg::rsp_word_t pending_lookups [$];

  bit          steady;
  bit          hold_request;
  int unsigned mismatches;
  int unsigned words_sent;
  int unsigned loads_sent;
  int unsigned queries_sent;
  int unsigned clears_sent;
  int unsigned lookups_checked;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void src_clear();
    src_line_start[0] = 0;
    src_text_end[0]   = 0;
    src_lines         = 1;
    src_bytes         = 0;
    src_open          = 1'b1;
    src_after_cr      = 1'b0;
    src_dropped       = 1'b0;
  endfunction

  function automatic void src_load(input logic [BYTE_W-1:0] b);
    int unsigned pos;
    bit          is_term;
    if (src_bytes >= BYTE_LIMIT) begin
      src_dropped = 1'b1;
      return;
    end
    pos       = src_bytes;
    src_bytes = src_bytes + 1;
    is_term   = (b == ltoc_pkg::CHAR_LF) || (b == ltoc_pkg::CHAR_CR);
    // The LF of a CR LF pair is swallowed by the terminator.
    if (src_after_cr) begin
      src_after_cr = 1'b0;
      if (b == ltoc_pkg::CHAR_LF) return;
    end
    if (!src_open) begin
      if (src_lines >= MAX_LINES) begin
        src_dropped = 1'b1;
        if (b == ltoc_pkg::CHAR_CR) src_after_cr = 1'b1;
        return;
      end
      src_line_start[src_lines] = pos;
      src_text_end[src_lines]   = pos;
      src_lines = src_lines + 1;
      src_open  = 1'b1;
    end
    if (is_term) begin
      src_open = 1'b0;
      if (b == ltoc_pkg::CHAR_CR) src_after_cr = 1'b1;
    end else begin
      src_text_end[src_lines-1] = pos + 1;
    end
  endfunction

  function automatic ltoc_pkg::rsp_word_t src_lookup(input logic [QOFF_W-1:0] offset);
    int unsigned         lo;
    int unsigned         hi;
    int unsigned         mid;
    int unsigned         vis;
    ltoc_pkg::rsp_word_t r;
    lo = 0;
    hi = src_lines;
    while (hi - lo > 1) begin
      mid = lo + (hi - lo) / 2;
      if (src_line_start[mid] <= offset) lo = mid;
      else hi = mid;
    end
    vis = (offset < src_text_end[lo]) ? offset : src_text_end[lo];
    r.line_index       = LINE_W'(lo);
    r.column_index     = COLUMN_W'(vis - src_line_start[lo]);
    r.capacity_dropped = src_dropped;
    return r;
  endfunction

  // Offer one word, wait for it to be taken, then update the model.
  task automatic push_word(input ltoc_pkg::req_word_t w, input bit typed,
                           input ltoc_pkg::rsp_word_t want);
    ltoc_pkg::rsp_word_t exp_word;
    while (!steady && $urandom_range(99) < 10) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_word  <= w;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    words_sent = words_sent + 1;
    case (w.operation)
      ltoc_pkg::OP_LOAD: begin
        src_load(w.source_byte);
        loads_sent = loads_sent + 1;
      end
      ltoc_pkg::OP_QUERY: begin
        exp_word = typed ? want : src_lookup(w.query_offset);
        pending_lookups = {pending_lookups, exp_word};
        queries_sent = queries_sent + 1;
      end
      ltoc_pkg::OP_CLEAR: begin
        src_clear();
        clears_sent = clears_sent + 1;
      end
      default: ;
    endcase
  endtask

  // Unused fields carry random noise so the block must ignore them.
  task automatic send_load(input logic [BYTE_W-1:0] b);
    ltoc_pkg::req_word_t w;
    w.operation    = ltoc_pkg::OP_LOAD;
    w.source_byte  = b;
    w.query_offset = QOFF_W'($urandom);
    push_word(w, 1'b0, EMPTY_LOOKUP);
  endtask

  task automatic send_query(input logic [QOFF_W-1:0] offset);
    ltoc_pkg::req_word_t w;
    w.operation    = ltoc_pkg::OP_QUERY;
    w.source_byte  = BYTE_W'($urandom);
    w.query_offset = offset;
    push_word(w, 1'b0, EMPTY_LOOKUP);
  endtask

  task automatic send_clear();
    ltoc_pkg::req_word_t w;
    w.operation    = ltoc_pkg::OP_CLEAR;
    w.source_byte  = BYTE_W'($urandom);
    w.query_offset = QOFF_W'($urandom);
    push_word(w, 1'b0, EMPTY_LOOKUP);
  endtask

  function automatic logic [BYTE_W-1:0] text_byte();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(255));
    while (b == ltoc_pkg::CHAR_LF || b == ltoc_pkg::CHAR_CR);
    return b;
  endfunction

  // Mostly offsets in or just past the loaded text, sometimes anywhere.
  function automatic logic [QOFF_W-1:0] pick_offset();
    int unsigned top;
    if ($urandom_range(9) < 2) return QOFF_W'($urandom);
    top = (src_bytes + 3 > 65535) ? 65535 : src_bytes + 3;
    return QOFF_W'($urandom_range(top));
  endfunction

  task automatic send_terminator(input bit may_omit);
    case ($urandom_range(3))
      0: send_load(ltoc_pkg::CHAR_LF);
      1: send_load(ltoc_pkg::CHAR_CR);
      2: begin
        send_load(ltoc_pkg::CHAR_CR);
        send_load(ltoc_pkg::CHAR_LF);
      end
      default: if (!may_omit) send_load(ltoc_pkg::CHAR_LF);
    endcase
  endtask

  task automatic send_text(input int unsigned lines);
    int unsigned len;
    for (int i = 0; i < lines; i++) begin
      len = $urandom_range(12);
      for (int j = 0; j < len; j++) begin
        // A few raw bytes, terminators included, break up the line structure.
        if ($urandom_range(7) == 0) send_load(BYTE_W'($urandom_range(255)));
        else send_load(text_byte());
      end
      send_terminator(i == lines - 1);
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches = mismatches + 1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_lookups.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual line %0d column %0d",
                 $time, rsp_word.line_index, rsp_word.column_index);
        mismatches = mismatches + 1;
      end else begin
        check_field("line_index", pending_lookups[0].line_index, rsp_word.line_index);
        check_field("column_index", pending_lookups[0].column_index, rsp_word.column_index);
        check_field("capacity_dropped", pending_lookups[0].capacity_dropped,
                    rsp_word.capacity_dropped);
        void'(pending_lookups.pop_front());
        lookups_checked = lookups_checked + 1;
      end
    end
  end

  // Result side: random stalls, or one long hold-off when asked for.
  initial begin
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        rsp_stall <= !steady && ($urandom_range(99) < 10);
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("%0t: timeout with %0d results outstanding", $time, pending_lookups.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int unsigned first_random;
    bit          held;
    steady          = 1'b0;
    hold_request    = 1'b0;
    held            = 1'b0;
    mismatches      = 0;
    words_sent      = 0;
    loads_sent      = 0;
    queries_sent    = 0;
    clears_sent     = 0;
    lookups_checked = 0;
    src_clear();
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req_word  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      push_word(ltoc_pkg::req_word_t'{operation: DIRECTED[i].op,
                                      source_byte: DIRECTED[i].data,
                                      query_offset: DIRECTED[i].offset},
                DIRECTED[i].typed, DIRECTED[i].want);
    end

    // Random text sessions with queries in between; one stretch runs with no
    // idling on either side.
    first_random = words_sent;
    while (words_sent - first_random < RANDOM_ITEMS) begin
      steady = (words_sent - first_random >= RANDOM_ITEMS / 8) &&
               (words_sent - first_random < 3 * RANDOM_ITEMS / 8);
      if ($urandom_range(2) == 0) send_clear();
      send_text($urandom_range(1, 8));
      repeat ($urandom_range(2, 6)) send_query(pick_offset());
      if (!held && words_sent - first_random > RANDOM_ITEMS / 2) begin
        // Queries pile up behind a stalled result until the input stalls too.
        held = 1'b1;
        hold_request = 1'b1;
        repeat (12) send_query(pick_offset());
      end
    end
    steady = 1'b0;
    send_query(16'hFFFF);
    send_query(16'h0000);

    req_valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d loads, %0d queries and %0d clears; %0d lookups checked.",
             loads_sent, queries_sent, clears_sent, lookups_checked);
    $display("Covered LF, CR and CR LF line ends, offsets past the text and a %0d-cycle hold-off.",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/ltoc_pkg.sv
hdl/ltoc_ctrl.sv
hdl/ltoc_dpath.sv
hdl/line_table_offset_to_line_column.sv
sim/line_table_offset_to_line_column_test.sv
